// File: hdl/hpd_pkg.sv
// hpd_pkg: shared widths, register codes, pipeline item types and the
// restoring-division step used by the hierarchical distance unit
// no dependencies
package hpd_pkg;

	localparam int MAX_LEVELS      = 3;
	localparam int LEVEL_BITS      = 2;
	localparam int RADIX_BITS      = 8;
	localparam int DIST_BITS       = 16;
	localparam int PROD_BITS       = 24;
	localparam int DIVISOR_BITS    = 16;
	localparam int STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES      = PROD_BITS / STEPS_PER_STAGE;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QPTR_BITS       = 2;
	localparam int CNT_BITS        = QPTR_BITS + 1;
	localparam int APB_ADDR_BITS   = 5;
	localparam int APB_DATA_BITS   = 32;

	typedef enum logic [2:0] {
		REG_LEVEL_COUNT,
		REG_RADIX0,
		REG_RADIX1,
		REG_RADIX2,
		REG_DIST0,
		REG_DIST1,
		REG_DIST2
	} reg_idx_t;

	typedef struct packed {
		logic [RADIX_BITS-1:0] radix0;
		logic [RADIX_BITS-1:0] radix1;
		logic [RADIX_BITS-1:0] radix2;
		logic [DIST_BITS-1:0]  dist0;
		logic [DIST_BITS-1:0]  dist1;
		logic [DIST_BITS-1:0]  dist2;
	} cfg_t;

	typedef struct packed {
		logic [DIVISOR_BITS-1:0] rem;
		logic [PROD_BITS-1:0]    nq;
	} div_state_t;

	typedef struct packed {
		logic                    err;
		logic                    ne;
		logic [DIVISOR_BITS-1:0] p2;
		logic [PROD_BITS-1:0]    a;
		logic [PROD_BITS-1:0]    b;
	} entry_t;

	typedef struct packed {
		logic                    err;
		logic                    ne;
		logic [DIVISOR_BITS-1:0] p2;
		div_state_t              a0;
		div_state_t              b0;
		div_state_t              a1;
		div_state_t              b1;
	} div_item_t;

	// shifts numerator bits into the remainder, quotient bits fill in from the bottom
	function automatic div_state_t div_steps(div_state_t s, logic [DIVISOR_BITS-1:0] d);
		div_state_t r;
		logic [DIVISOR_BITS:0] t;
		r = s;
		for (int i = 0; i < STEPS_PER_STAGE; i++) begin
			t = {r.rem, r.nq[PROD_BITS-1]};
			if (t >= {1'b0, d}) begin
				r.rem = DIVISOR_BITS'(t - {1'b0, d});
				r.nq  = {r.nq[PROD_BITS-2:0], 1'b1};
			end else begin
				r.rem = t[DIVISOR_BITS-1:0];
				r.nq  = {r.nq[PROD_BITS-2:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

// File: hdl/hpd_pair_if.sv
// hpd_pair_if: valid/ready channel carrying a pair of element indices
// no dependencies
interface hpd_pair_if #(
	parameter int INDEX_BITS = 24
);
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] pe_first;
	logic [INDEX_BITS-1:0] pe_second;

	modport source (output valid, output pe_first, output pe_second, input ready);
	modport sink   (input valid, input pe_first, input pe_second, output ready);
endinterface

// File: hdl/hpd_result_if.sv
// hpd_result_if: valid/ready channel carrying a distance result
// no dependencies
interface hpd_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] distance;
	logic        index_error;

	modport source (output valid, output distance, output index_error, input ready);
	modport sink   (input valid, input distance, input index_error, output ready);
endinterface

// File: hdl/hierarchical_pe_distance_unit.sv
// hierarchical_pe_distance_unit: top level with the configuration registers,
// front classifier, queue and divider back end; depends on hpd_pkg, hpd_front,
// hpd_queue, hpd_back, hpd_pair_if and hpd_result_if
// throughput: one item per cycle while the result channel is not stalled, set by the six-stage divider pipeline
// a four-entry queue lets front and back stall independently
// reset: asynchronous, clears pipelines and queue, config to 3 levels, radix 1, distance 0
module hierarchical_pe_distance_unit #(
	parameter int INDEX_BITS = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	hpd_pair_if.sink                           pair,
	hpd_result_if.source                       result,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [hpd_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [hpd_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [hpd_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                               pready
);

	logic [hpd_pkg::LEVEL_BITS-1:0]  level_count_q;
	logic [hpd_pkg::RADIX_BITS-1:0]  radix0_q;
	logic [hpd_pkg::RADIX_BITS-1:0]  radix1_q;
	logic [hpd_pkg::RADIX_BITS-1:0]  radix2_q;
	logic [hpd_pkg::DIST_BITS-1:0]   dist0_q;
	logic [hpd_pkg::DIST_BITS-1:0]   dist1_q;
	logic [hpd_pkg::DIST_BITS-1:0]   dist2_q;
	logic [hpd_pkg::LEVEL_BITS-1:0]  levels;
	hpd_pkg::reg_idx_t               reg_idx;
	logic                            wr_en;
	hpd_pkg::cfg_t                   cfg;
	logic                            push;
	logic                            pop;
	logic                            full;
	logic                            empty;
	hpd_pkg::entry_t                 push_data;
	hpd_pkg::entry_t                 head;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = hpd_pkg::reg_idx_t'(paddr[hpd_pkg::APB_ADDR_BITS-1:2]);

	always_comb begin
		if (level_count_q == '0)
			levels = hpd_pkg::LEVEL_BITS'(1);
		else if (level_count_q > hpd_pkg::LEVEL_BITS'(hpd_pkg::MAX_LEVELS))
			levels = hpd_pkg::LEVEL_BITS'(hpd_pkg::MAX_LEVELS);
		else
			levels = level_count_q;
	end

	// unused levels and zero radices count as radix one
	always_comb begin
		cfg.radix0 = (radix0_q != '0) ? radix0_q : hpd_pkg::RADIX_BITS'(1);
		cfg.radix1 = (levels >= hpd_pkg::LEVEL_BITS'(2) && radix1_q != '0)
		             ? radix1_q : hpd_pkg::RADIX_BITS'(1);
		cfg.radix2 = (levels >= hpd_pkg::LEVEL_BITS'(3) && radix2_q != '0)
		             ? radix2_q : hpd_pkg::RADIX_BITS'(1);
		cfg.dist0  = dist0_q;
		cfg.dist1  = dist1_q;
		cfg.dist2  = dist2_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_count_q <= hpd_pkg::LEVEL_BITS'(3);
			radix0_q      <= hpd_pkg::RADIX_BITS'(1);
			radix1_q      <= hpd_pkg::RADIX_BITS'(1);
			radix2_q      <= hpd_pkg::RADIX_BITS'(1);
			dist0_q       <= '0;
			dist1_q       <= '0;
			dist2_q       <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				hpd_pkg::REG_LEVEL_COUNT: level_count_q <= pwdata[hpd_pkg::LEVEL_BITS-1:0];
				hpd_pkg::REG_RADIX0:      radix0_q      <= pwdata[hpd_pkg::RADIX_BITS-1:0];
				hpd_pkg::REG_RADIX1:      radix1_q      <= pwdata[hpd_pkg::RADIX_BITS-1:0];
				hpd_pkg::REG_RADIX2:      radix2_q      <= pwdata[hpd_pkg::RADIX_BITS-1:0];
				hpd_pkg::REG_DIST0:       dist0_q       <= pwdata[hpd_pkg::DIST_BITS-1:0];
				hpd_pkg::REG_DIST1:       dist1_q       <= pwdata[hpd_pkg::DIST_BITS-1:0];
				hpd_pkg::REG_DIST2:       dist2_q       <= pwdata[hpd_pkg::DIST_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			hpd_pkg::REG_LEVEL_COUNT: prdata = hpd_pkg::APB_DATA_BITS'(level_count_q);
			hpd_pkg::REG_RADIX0:      prdata = hpd_pkg::APB_DATA_BITS'(radix0_q);
			hpd_pkg::REG_RADIX1:      prdata = hpd_pkg::APB_DATA_BITS'(radix1_q);
			hpd_pkg::REG_RADIX2:      prdata = hpd_pkg::APB_DATA_BITS'(radix2_q);
			hpd_pkg::REG_DIST0:       prdata = hpd_pkg::APB_DATA_BITS'(dist0_q);
			hpd_pkg::REG_DIST1:       prdata = hpd_pkg::APB_DATA_BITS'(dist1_q);
			hpd_pkg::REG_DIST2:       prdata = hpd_pkg::APB_DATA_BITS'(dist2_q);
			default:                  prdata = '0;
		endcase
	end

	hpd_front #(
		.INDEX_BITS(INDEX_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair),
		.cfg    (cfg),
		.full   (full),
		.push   (push),
		.entry  (push_data)
	);

	hpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (full),
		.empty     (empty),
		.head      (head)
	);

	hpd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.cfg    (cfg),
		.result (result)
	);

endmodule

// File: hdl/hpd_front.sv
// hpd_front: accepts index pairs, forms the radix products and flags
// out-of-range indices; depends on hpd_pkg and hpd_pair_if
module hpd_front #(
	parameter int INDEX_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	hpd_pair_if.sink            pair,
	input  hpd_pkg::cfg_t       cfg,
	input  logic                full,
	output logic                push,
	output hpd_pkg::entry_t     entry
);

	localparam int WIDE = (INDEX_BITS > hpd_pkg::PROD_BITS) ? INDEX_BITS : hpd_pkg::PROD_BITS;

	logic                              front_en;
	logic                              valid_s1;
	logic                              valid_s2;
	logic [INDEX_BITS-1:0]             a_s1;
	logic [INDEX_BITS-1:0]             b_s1;
	logic [hpd_pkg::DIVISOR_BITS-1:0]  p2_s1;
	logic [hpd_pkg::PROD_BITS-1:0]     prod;
	logic [WIDE-1:0]                   a_w;
	logic [WIDE-1:0]                   b_w;
	logic [WIDE-1:0]                   prod_w;
	hpd_pkg::entry_t                   entry_s2;

	assign front_en   = !valid_s2 || !full;
	assign pair.ready = front_en;
	assign push       = valid_s2 && !full;
	assign entry      = entry_s2;

	assign prod   = hpd_pkg::PROD_BITS'(p2_s1) * hpd_pkg::PROD_BITS'(cfg.radix2);
	assign a_w    = WIDE'(a_s1);
	assign b_w    = WIDE'(b_s1);
	assign prod_w = WIDE'(prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (front_en) begin
			valid_s1 <= pair.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (front_en) begin
			a_s1         <= pair.pe_first;
			b_s1         <= pair.pe_second;
			p2_s1        <= hpd_pkg::DIVISOR_BITS'(cfg.radix0)
			                * hpd_pkg::DIVISOR_BITS'(cfg.radix1);
			entry_s2.err <= (a_w >= prod_w) || (b_w >= prod_w);
			entry_s2.ne  <= a_s1 != b_s1;
			entry_s2.p2  <= p2_s1;
			entry_s2.a   <= a_w[hpd_pkg::PROD_BITS-1:0];
			entry_s2.b   <= b_w[hpd_pkg::PROD_BITS-1:0];
		end
	end

endmodule

// File: hdl/hpd_queue.sv
// hpd_queue: short fifo between the front classifier and the divider back end
// depends on hpd_pkg
module hpd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hpd_pkg::entry_t push_data,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output hpd_pkg::entry_t head
);

	hpd_pkg::entry_t                mem_q [hpd_pkg::QUEUE_DEPTH];
	logic [hpd_pkg::QPTR_BITS-1:0]  wr_ptr_q;
	logic [hpd_pkg::QPTR_BITS-1:0]  rd_ptr_q;
	logic [hpd_pkg::CNT_BITS-1:0]   count_q;

	assign full  = count_q == hpd_pkg::CNT_BITS'(hpd_pkg::QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// File: hdl/hpd_back.sv
// hpd_back: pipelined restoring dividers that find the highest differing
// digit, then selects the level distance; depends on hpd_pkg and hpd_result_if
module hpd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  hpd_pkg::entry_t head,
	input  logic            empty,
	output logic            pop,
	input  hpd_pkg::cfg_t   cfg,
	hpd_result_if.source    result
);

	localparam int N = hpd_pkg::DIV_STAGES;

	logic                                back_en;
	logic                                valid_s [1:N];
	hpd_pkg::div_item_t                  data_s  [1:N];
	hpd_pkg::div_item_t                  nxt     [1:N];
	hpd_pkg::div_item_t                  init;
	hpd_pkg::div_item_t                  last;
	logic [hpd_pkg::DIVISOR_BITS-1:0]    d0;
	logic                                out_valid_q;
	logic [hpd_pkg::DIST_BITS-1:0]       distance_q;
	logic                                index_error_q;
	logic [hpd_pkg::DIST_BITS-1:0]       dist_sel;

	assign back_en = !out_valid_q || result.ready;
	assign pop     = back_en && !empty;
	assign d0      = hpd_pkg::DIVISOR_BITS'(cfg.radix0);
	assign last    = data_s[N];

	assign result.valid       = out_valid_q;
	assign result.distance    = distance_q;
	assign result.index_error = index_error_q;

	always_comb begin
		init.err    = head.err;
		init.ne     = head.ne;
		init.p2     = head.p2;
		init.a0.rem = '0;
		init.a0.nq  = head.a;
		init.b0.rem = '0;
		init.b0.nq  = head.b;
		init.a1.rem = '0;
		init.a1.nq  = head.a;
		init.b1.rem = '0;
		init.b1.nq  = head.b;
	end

	always_comb begin
		for (int k = 1; k <= N; k++) begin
			nxt[k] = (k == 1) ? init : data_s[k-1];
			nxt[k].a0 = hpd_pkg::div_steps(nxt[k].a0, d0);
			nxt[k].b0 = hpd_pkg::div_steps(nxt[k].b0, d0);
			nxt[k].a1 = hpd_pkg::div_steps(nxt[k].a1, nxt[k].p2);
			nxt[k].b1 = hpd_pkg::div_steps(nxt[k].b1, nxt[k].p2);
		end
	end

	// quotient by r0*r1 is the top digit, quotient by r0 covers the top two
	always_comb begin
		if (last.err)
			dist_sel = '0;
		else if (last.a1.nq != last.b1.nq)
			dist_sel = cfg.dist2;
		else if (last.a0.nq != last.b0.nq)
			dist_sel = cfg.dist1;
		else if (last.ne)
			dist_sel = cfg.dist0;
		else
			dist_sel = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= N; k++)
				valid_s[k] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (back_en) begin
			valid_s[1] <= !empty;
			for (int k = 2; k <= N; k++)
				valid_s[k] <= valid_s[k-1];
			out_valid_q <= valid_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (back_en) begin
			for (int k = 1; k <= N; k++)
				data_s[k] <= nxt[k];
			distance_q    <= dist_sel;
			index_error_q <= last.err;
		end
	end

endmodule

// File: dv/hierarchical_pe_distance_unit_test.sv
// hierarchical_pe_distance_unit_test: self-checking bench for the hierarchical
// element distance unit, scoreboard class plus APB and stream driver tasks
// depends on hpd_pkg, hpd_pair_if, hpd_result_if and hierarchical_pe_distance_unit
module hierarchical_pe_distance_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDX_W      = 24;
	localparam int IDLE_LIMIT = 3000;

	typedef struct packed {
		logic [15:0] distance;
		logic        index_error;
	} hop_t;

	class distance_board;
		logic [1:0]  level_cnt;
		logic [7:0]  radix [3];
		logic [15:0] hop_dist [3];
		hop_t        hop_q [$];
		int          mismatches;

		function new();
			level_cnt  = 2'd3;
			mismatches = 0;
			for (int i = 0; i < 3; i++) begin
				radix[i]    = 8'd1;
				hop_dist[i] = 16'd0;
			end
		endfunction

		function void write_reg(hpd_pkg::reg_idx_t idx, logic [31:0] val);
			case (idx)
				hpd_pkg::REG_LEVEL_COUNT: level_cnt   = val[1:0];
				hpd_pkg::REG_RADIX0:      radix[0]    = val[7:0];
				hpd_pkg::REG_RADIX1:      radix[1]    = val[7:0];
				hpd_pkg::REG_RADIX2:      radix[2]    = val[7:0];
				hpd_pkg::REG_DIST0:       hop_dist[0] = val[15:0];
				hpd_pkg::REG_DIST1:       hop_dist[1] = val[15:0];
				hpd_pkg::REG_DIST2:       hop_dist[2] = val[15:0];
				default: ;
			endcase
		endfunction

		function longint unsigned eff_radix(int lvl);
			int unsigned n;
			n = (level_cnt == 2'd0) ? 1 : level_cnt;
			if (lvl >= n || radix[lvl] == 8'd0)
				return 1;
			return radix[lvl];
		endfunction

		function longint unsigned span();
			longint unsigned p;
			p = 1;
			for (int i = 0; i < 3; i++)
				p *= eff_radix(i);
			return p;
		endfunction

		function void note_pair(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
			longint unsigned r [3];
			longint unsigned prod, va, vb;
			hop_t h;
			prod = span();
			h.distance    = 16'd0;
			h.index_error = 1'b0;
			if (a >= prod || b >= prod) begin
				h.index_error = 1'b1;
			end else begin
				va = a;
				vb = b;
				for (int i = 0; i < 3; i++) begin
					r[i] = eff_radix(i);
					if (va % r[i] != vb % r[i])
						h.distance = hop_dist[i];
					va = va / r[i];
					vb = vb / r[i];
				end
			end
			hop_q = {hop_q, h};
		endfunction

		function void check_result(logic [15:0] d, logic e);
			hop_t h;
			if (hop_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: distance=%0d index_error=%0b", d, e);
				return;
			end
			h = hop_q.pop_front();
			if (d !== h.distance || e !== h.index_error) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: expected distance=%0d index_error=%0b, ",
						"got distance=%0d index_error=%0b"},
						h.distance, h.index_error, d, e);
			end
		endfunction

		function int pending();
			return hop_q.size();
		endfunction
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              psel;
	logic                              penable;
	logic                              pwrite;
	logic [hpd_pkg::APB_ADDR_BITS-1:0] paddr;
	logic [hpd_pkg::APB_DATA_BITS-1:0] pwdata;
	logic [hpd_pkg::APB_DATA_BITS-1:0] prdata;
	logic                              pready;

	hpd_pair_if #(.INDEX_BITS(IDX_W)) pair_ch ();
	hpd_result_if                     res_ch ();

	hierarchical_pe_distance_unit #(.INDEX_BITS(IDX_W)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pair    (pair_ch),
		.result  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	distance_board board = new();

	int rx_mode;
	bit hold_req;
	int idle_cycles;
	int gap_max;
	int burst_max;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// acceptance monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pair_ch.valid && pair_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (pair_ch.valid && pair_ch.ready)
				board.note_pair(pair_ch.pe_first, pair_ch.pe_second);
			if (res_ch.valid && res_ch.ready)
				board.check_result(res_ch.distance, res_ch.index_error);
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// result sink with its own stall pattern
	initial begin
		int rx_tick;
		rx_tick = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rx_tick++;
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (120) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				case (rx_mode)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= ($urandom_range(0, 3) != 0);
					2: res_ch.ready <= ((rx_tick % 11) < 6);
					default: res_ch.ready <= ($urandom_range(0, 1) == 1);
				endcase
			end
		end
	end

	task automatic apb_write(hpd_pkg::reg_idx_t idx, logic [31:0] val);
		logic [31:0] junk;
		junk = ($urandom_range(0, 1) == 1) ? $urandom : 32'd0;
		case (idx)
			hpd_pkg::REG_LEVEL_COUNT: junk[1:0] = 2'd0;
			hpd_pkg::REG_RADIX0, hpd_pkg::REG_RADIX1, hpd_pkg::REG_RADIX2:
				junk[7:0] = 8'd0;
			default:                  junk[15:0] = 16'd0;
		endcase
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val | junk;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		board.write_reg(idx, val | junk);
	endtask

	task automatic load_config(logic [1:0] lc, logic [7:0] r0, logic [7:0] r1, logic [7:0] r2,
			logic [15:0] d0, logic [15:0] d1, logic [15:0] d2);
		apb_write(hpd_pkg::REG_LEVEL_COUNT, 32'(lc));
		apb_write(hpd_pkg::REG_RADIX0, 32'(r0));
		apb_write(hpd_pkg::REG_RADIX1, 32'(r1));
		apb_write(hpd_pkg::REG_RADIX2, 32'(r2));
		apb_write(hpd_pkg::REG_DIST0, 32'(d0));
		apb_write(hpd_pkg::REG_DIST1, 32'(d1));
		apb_write(hpd_pkg::REG_DIST2, 32'(d2));
	endtask

	task automatic send_pair(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
		pair_ch.valid     <= 1'b1;
		pair_ch.pe_first  <= a;
		pair_ch.pe_second <= b;
		do
			@(posedge clk);
		while (!pair_ch.ready);
	endtask

	task automatic drain();
		pair_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_radix();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd255;
			default: return 8'($urandom_range(2, 16));
		endcase
	endfunction

	function automatic logic [15:0] pick_dist();
		case ($urandom_range(0, 3))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic void make_pair(output logic [IDX_W-1:0] a, output logic [IDX_W-1:0] b);
		longint unsigned prod, va, vb, w, da, db, r;
		int k;
		prod = board.span();
		case ($urandom_range(0, 9))
			7: begin
				case ($urandom_range(0, 2))
					0: va = prod - 1;
					1: va = prod;
					default: va = 0;
				endcase
				vb = $urandom % prod;
				if ($urandom_range(0, 1) == 1) begin
					w  = va;
					va = vb;
					vb = w;
				end
			end
			8: begin
				va = IDX_W'($urandom);
				vb = IDX_W'($urandom);
			end
			9: begin
				va = IDX_W'($urandom);
				vb = $urandom % prod;
			end
			default: begin
				// digits from k upward are shared, so the pair first differs below k
				k  = $urandom_range(0, 3);
				va = 0;
				vb = 0;
				w  = 1;
				for (int i = 0; i < 3; i++) begin
					r  = board.eff_radix(i);
					da = $urandom % r;
					db = (i >= k) ? da : $urandom % r;
					va += da * w;
					vb += db * w;
					w  *= r;
				end
			end
		endcase
		a = IDX_W'(va);
		b = IDX_W'(vb);
	endfunction

	task automatic run_random(int count, int hold_at);
		logic [IDX_W-1:0] a, b;
		int burst_left;
		int gap;
		burst_left = $urandom_range(1, burst_max);
		for (int n = 0; n < count; n++) begin
			if (n == hold_at)
				hold_req = 1'b1;
			make_pair(a, b);
			send_pair(a, b);
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, burst_max);
				gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
				if (gap > 0) begin
					pair_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	endtask

	initial begin
		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		pair_ch.valid     <= 1'b0;
		pair_ch.pe_first  <= '0;
		pair_ch.pe_second <= '0;
		rx_mode     = 0;
		hold_req    = 1'b0;
		idle_cycles = 0;
		gap_max     = 0;
		burst_max   = 8;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: only index zero is in range
		send_pair(24'd0, 24'd0);
		send_pair(24'd0, 24'd1);
		send_pair(24'hFFFFFF, 24'hFFFFFF);
		drain();

		load_config(2'd3, 8'd255, 8'd255, 8'd255, 16'd0, 16'hFFFF, 16'hA5A5);
		send_pair(24'd0, 24'd0);
		send_pair(24'd0, 24'd16581374);
		send_pair(24'd254, 24'd0);
		send_pair(24'd255, 24'd0);
		send_pair(24'd65025, 24'd0);
		send_pair(24'd16581374, 24'd16581374);
		send_pair(24'd16581375, 24'd0);
		send_pair(24'd0, 24'hFFFFFF);
		send_pair(24'hFFFFFF, 24'hFFFFFF);
		drain();

		// zero level count behaves as one level
		load_config(2'd0, 8'd200, 8'd7, 8'd9, 16'hFFFF, 16'd5, 16'd6);
		send_pair(24'd0, 24'd199);
		send_pair(24'd199, 24'd200);
		send_pair(24'd5, 24'd5);
		send_pair(24'd3, 24'd4);
		drain();

		// zero radix behaves as one
		load_config(2'd2, 8'd0, 8'd10, 8'd255, 16'd1, 16'd2, 16'd3);
		send_pair(24'd0, 24'd9);
		send_pair(24'd9, 24'd10);
		send_pair(24'd4, 24'd4);
		drain();

		load_config(2'd1, 8'd255, 8'd3, 8'd3, 16'd777, 16'd1, 16'd2);
		send_pair(24'd0, 24'd254);
		send_pair(24'd255, 24'd0);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 0)
				load_config(2'd3, 8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
			else if (ph == 1)
				load_config(2'd1, 8'd255, 8'd0, 8'd0, 16'hFFFF, 16'd0, 16'd0);
			else
				load_config(2'($urandom_range(0, 3)), pick_radix(), pick_radix(), pick_radix(),
					pick_dist(), pick_dist(), pick_dist());
			rx_mode   = ph % 4;
			gap_max   = (ph % 3 == 0) ? 0 : $urandom_range(1, 12);
			burst_max = $urandom_range(1, 20);
			run_random(200, (ph == 2) ? 50 : -1);
			drain();
		end

		repeat (20) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
